// File: rtl/core/fsc_pkg.sv
package fsc_pkg;

    localparam int FRAME_BYTES  = 21;
    localparam int BUFFER_LIMIT = 500;
    localparam int STORE_DEPTH  = 512;
    localparam int MAX_RESULTS  = 64;

    localparam int KEEP_LIMIT = (BUFFER_LIMIT < STORE_DEPTH) ? BUFFER_LIMIT : STORE_DEPTH;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
    localparam int K_W        = $clog2(FRAME_BYTES);
    localparam int NFR_W      = $clog2(MAX_RESULTS);
    localparam int OFFSET_W   = 9;
    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

    localparam logic [BYTE_W-1:0] SOF_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SOF_SECOND_RST = 8'h5A;
    localparam logic [CRC_W-1:0]  CRC_SEED_RST   = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_SOF_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOF_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED   = 2'd2;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic store_wr;
        logic scan_init;
        logic pos_step;
        logic pos_skip;
        logic k_clr;
        logic k_inc;
        logic crc_init;
        logic crc_upd;
        logic found_set;
        logic nfr_inc;
        logic fill_clr;
    } fsc_cmd_t;

    typedef struct packed {
        logic fits;
        logic byte_ok;
        logic k_last;
        logic nfr_full;
    } fsc_status_t;

    typedef struct packed {
        logic push;
        logic summary;
    } fsc_out_cmd_t;

    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W - BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/frame_scan_crc16_check_top.sv
// Receive-buffer frame search with CRC-16 check. Bytes stream in on the s_ side at one per
// cycle and are kept up to the buffer limit; later bytes are dropped. The request flagged
// with tlast closes the buffer and starts a scan from offset 0, during which s_tready is low.
// Each start position that holds the two start-of-frame bytes, and leaves room for a whole
// frame, is checked by a reflected CRC-16 (poly 0x8408, seed from crc_seed, no final xor)
// against the frame's last two bytes, low byte first. A good frame gives a result with its
// offset and the scan jumps past it; any other position advances by one byte. A summary
// result (tuser = 1, tlast = 1) with the found flag always ends the buffer; at most 63 frame
// results are sent per buffer. The scan reads the buffer through one registered read port,
// one byte per pass through ST_RD and ST_CHK; a result is held back while m_tready
// keeps the output register full.
module frame_scan_crc16_check_top
    import fsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // end_of_buffer
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [8:0] frame_offset, [9] frame_found, rest zero
    output logic                  m_tuser,   // item_kind
    output logic                  m_tlast    // last_result
);

    fsc_cmd_t            cmd;
    fsc_status_t         status;
    fsc_out_cmd_t        out_cmd;
    logic [OFFSET_W-1:0] dp_offset;
    logic                dp_found;
    logic                out_free;

    logic                m_valid_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic                m_found_reg;
    logic                m_kind_reg;
    logic                m_last_reg;

    fsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_end   (s_tlast),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .out_cmd  (out_cmd)
    );

    fsc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_byte      (s_tdata[BYTE_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .frame_offset (dp_offset),
        .frame_found  (dp_found)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // load the payload only on a new request
    always_ff @(posedge aclk) begin
        if (out_cmd.push) begin
            m_kind_reg   <= out_cmd.summary ? KIND_SUMMARY : KIND_FRAME;
            m_offset_reg <= out_cmd.summary ? '0 : dp_offset;
            m_found_reg  <= out_cmd.summary ? dp_found : 1'b1;
            m_last_reg   <= out_cmd.summary;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - OFFSET_W - 1){1'b0}}, m_found_reg, m_offset_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    a_summary_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
        else $error("tlast does not match the summary kind");

    a_frame_found : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_FRAME)) |->
            (m_tdata[OFFSET_W] && (m_tdata[OFFSET_W-1:0] <= OFFSET_W'(KEEP_LIMIT - FRAME_BYTES))))
        else $error("frame result with bad offset or found flag");

    a_no_load_on_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_FRAME)) |-> !s_tready)
        else $error("input taken while a frame result is pending");

    a_scan_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after the end of a buffer");

endmodule

// File: rtl/core/fsc_datapath.sv
module fsc_datapath
    import fsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [BYTE_W-1:0]     in_byte,
    input  fsc_cmd_t              cmd,
    output fsc_status_t           status,
    output logic [OFFSET_W-1:0]   frame_offset,
    output logic                  frame_found
);

    localparam logic [K_W-1:0] K_SOF1   = K_W'(0);
    localparam logic [K_W-1:0] K_SOF2   = K_W'(1);
    localparam logic [K_W-1:0] K_CRC_LO = K_W'(FRAME_BYTES - 2);
    localparam logic [K_W-1:0] K_CRC_HI = K_W'(FRAME_BYTES - 1);

    logic [BYTE_W-1:0] byte_store_mem [STORE_DEPTH];

    logic [BYTE_W-1:0] sof_first_reg;
    logic [BYTE_W-1:0] sof_second_reg;
    logic [CRC_W-1:0]  crc_seed_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [NFR_W-1:0]  nfr_reg, nfr_next;
    logic              found_reg, found_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  rd_sum;
    logic              crc_phase;
    logic              byte_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sof_first_reg  <= SOF_FIRST_RST;
            sof_second_reg <= SOF_SECOND_RST;
            crc_seed_reg   <= CRC_SEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOF_FIRST:  sof_first_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_SOF_SECOND: sof_second_reg <= cfg_wdata[BYTE_W-1:0];
                REG_CRC_SEED:   crc_seed_reg   <= cfg_wdata[CRC_W-1:0];
                default: ;
            endcase
        end
    end

    // bytes past the keep limit are dropped
    always_ff @(posedge aclk) begin
        if (cmd.store_wr && (fill_reg < CNT_W'(KEEP_LIMIT))) begin
            byte_store_mem[fill_reg[ADDR_W-1:0]] <= in_byte;
        end
    end

    assign rd_sum = pos_reg + {{(CNT_W - K_W){1'b0}}, k_reg};

    always_ff @(posedge aclk) begin
        rd_data_reg <= byte_store_mem[rd_sum[ADDR_W-1:0]];
    end

    assign crc_phase = (k_reg < K_CRC_LO);

    always_comb begin
        if (k_reg == K_SOF1) begin
            byte_ok = (rd_data_reg == sof_first_reg);
        end else if (k_reg == K_SOF2) begin
            byte_ok = (rd_data_reg == sof_second_reg);
        end else if (k_reg == K_CRC_LO) begin
            byte_ok = (rd_data_reg == crc_reg[7:0]);
        end else if (k_reg == K_CRC_HI) begin
            byte_ok = (rd_data_reg == crc_reg[15:8]);
        end else begin
            byte_ok = 1'b1;
        end
    end

    always_comb begin
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        crc_next   = crc_reg;
        nfr_next   = nfr_reg;
        found_next = found_reg;
        if (cmd.store_wr && (fill_reg < CNT_W'(KEEP_LIMIT))) begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.fill_clr) begin
            fill_next = '0;
        end
        if (cmd.scan_init) begin
            pos_next   = '0;
            nfr_next   = '0;
            found_next = 1'b0;
        end
        if (cmd.pos_step) begin
            pos_next = pos_reg + CNT_W'(1);
        end
        if (cmd.pos_skip) begin
            pos_next = pos_reg + CNT_W'(FRAME_BYTES);
        end
        if (cmd.k_clr) begin
            k_next = '0;
        end
        if (cmd.k_inc) begin
            k_next = k_reg + K_W'(1);
        end
        if (cmd.crc_init) begin
            crc_next = crc_seed_reg;
        end
        if (cmd.crc_upd && crc_phase) begin
            crc_next = crc16_byte(crc_reg, rd_data_reg);
        end
        if (cmd.found_set) begin
            found_next = 1'b1;
        end
        if (cmd.nfr_inc) begin
            nfr_next = nfr_reg + NFR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
            nfr_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
            nfr_reg   <= nfr_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign status.fits     = ({1'b0, pos_reg} + (CNT_W + 1)'(FRAME_BYTES)) <= {1'b0, fill_reg};
    assign status.byte_ok  = byte_ok;
    assign status.k_last   = (k_reg == K_CRC_HI);
    assign status.nfr_full = (nfr_reg == NFR_W'(MAX_RESULTS - 1));

    assign frame_offset = OFFSET_W'(pos_reg);
    assign frame_found  = found_reg;

endmodule

// File: rtl/core/fsc_ctrl.sv
module fsc_ctrl
    import fsc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic         in_end,
    output logic         in_ready,
    input  logic         out_free,
    input  fsc_status_t  status,
    output fsc_cmd_t     cmd,
    output fsc_out_cmd_t out_cmd
);

    typedef enum logic [5:0] {
        ST_LOAD     = 6'b000001,
        ST_TEST     = 6'b000010,
        ST_RD       = 6'b000100,
        ST_CHK      = 6'b001000,
        ST_EMIT_FRM = 6'b010000,
        ST_EMIT_SUM = 6'b100000
    } fsc_state_t;

    fsc_state_t state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_cmd    = '0;
        case (state_reg)
            ST_LOAD: begin
                cmd.store_wr = accept;
                if (accept && in_end) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_TEST;
                end
            end
            ST_TEST: begin
                if (status.fits) begin
                    cmd.k_clr    = 1'b1;
                    cmd.crc_init = 1'b1;
                    state_next   = ST_RD;
                end else begin
                    state_next = ST_EMIT_SUM;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.crc_upd = 1'b1;
                if (!status.byte_ok) begin
                    cmd.pos_step = 1'b1;
                    state_next   = ST_TEST;
                end else if (status.k_last) begin
                    cmd.found_set = 1'b1;
                    // past the item limit, skip the frame without a request
                    if (status.nfr_full) begin
                        cmd.pos_skip = 1'b1;
                        state_next   = ST_TEST;
                    end else begin
                        state_next = ST_EMIT_FRM;
                    end
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_EMIT_FRM: begin
                if (out_free) begin
                    out_cmd.push = 1'b1;
                    cmd.nfr_inc  = 1'b1;
                    cmd.pos_skip = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            ST_EMIT_SUM: begin
                if (out_free) begin
                    out_cmd.push    = 1'b1;
                    out_cmd.summary = 1'b1;
                    cmd.fill_clr    = 1'b1;
                    state_next      = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
